FILE: src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the block-decomposed range sum core.
// ----------------------------------------------------------------------------
package brs_pkg;

  // Field and register widths
  localparam int REG_W      = 11;
  localparam int INDEX_W    = 10;
  localparam int VALUE_W    = 32;
  localparam int TOTAL_W    = 42;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Register select (paddr bit 2)
  localparam logic REG_SEL_ARRAY_LENGTH = 1'b0;
  localparam logic REG_SEL_BLOCK_LENGTH = 1'b1;

  // Register reset values
  localparam logic [REG_W-1:0] ARRAY_LENGTH_RST = 11'd1024;
  localparam logic [REG_W-1:0] BLOCK_LENGTH_RST = 11'd32;

  typedef struct packed {
    logic                      opcode;
    logic [INDEX_W-1:0]        element_index;
    logic signed [VALUE_W-1:0] element_value;
    logic [INDEX_W-1:0]        range_start;
    logic [INDEX_W-1:0]        range_end;
  } item_t;

  // Effective configuration: length in use and a nonzero block length
  typedef struct packed {
    logic [REG_W-1:0] len;
    logic [REG_W-1:0] blk;
  } cfg_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] range_total;
    logic                      status;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WR_READ,
    ST_WR_DIFF,
    ST_WR_STORE,
    ST_HEAD,
    ST_BLOCKS,
    ST_TAIL,
    ST_DONE
  } engine_state_t;

endpackage

FILE: src/brs_div.sv
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle. Splits an index into a
// block number and an offset inside the block.
// ----------------------------------------------------------------------------
module brs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [brs_pkg::REG_W-1:0]  dividend,
  input  logic [brs_pkg::REG_W-1:0]  divisor,
  output logic                       done,
  output logic [brs_pkg::REG_W-1:0]  quotient,
  output logic [brs_pkg::REG_W-1:0]  remainder
);

  localparam int W  = brs_pkg::REG_W;
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // One trial subtract per step
  assign shifted = {remainder, quotient[W-1]};
  assign trial   = shifted - {1'b0, divisor};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (cnt != '0) begin
      if (!trial[W]) begin
        remainder <= trial[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= shifted[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/brs_engine.sv
// ----------------------------------------------------------------------------
// brs_engine
// Sequencer, element and block-sum memories and the shared 42-bit adder.
// Handles updates, range walks and the clearing pass.
// ----------------------------------------------------------------------------
module brs_engine #(
  parameter int MAX_ELEMENTS  = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  brs_pkg::item_t   item,
  input  brs_pkg::cfg_t    cfg,
  input  logic             clear_req,
  output logic             idle,
  output logic             res_valid,
  output brs_pkg::result_t res,
  input  logic             res_ready
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int EW = ELEMENT_WIDTH;
  localparam int TW = brs_pkg::TOTAL_W;
  localparam int RW = brs_pkg::REG_W;
  localparam logic [AW-1:0] ClrLast = AW'(MAX_ELEMENTS - 1);

  brs_pkg::engine_state_t state, state_next;

  // Item registers
  logic                          op;
  logic [brs_pkg::INDEX_W-1:0]   idx;
  logic [EW-1:0]                 val;
  logic [RW-1:0]                 pos;
  logic [RW-1:0]                 last;
  logic [RW-1:0]                 off;
  logic [RW-1:0]                 blk;
  logic signed [TW-1:0]          sum;
  logic                          status;
  logic                          pend_elem;
  logic                          pend_bsum;
  logic [AW-1:0]                 clr_addr;

  // Memories
  logic [EW-1:0] elem_mem [MAX_ELEMENTS];
  logic [TW-1:0] bsum_mem [MAX_ELEMENTS];
  logic [EW-1:0] elem_q;
  logic [TW-1:0] bsum_q;

  logic          elem_re, bsum_re, elem_we, bsum_we;
  logic [AW-1:0] elem_raddr, bsum_raddr, elem_waddr, bsum_waddr;
  logic [EW-1:0] elem_wdata;
  logic [TW-1:0] bsum_wdata;

  // Shared adder
  logic [TW-1:0] alu_a, alu_b, alu_y;
  logic          alu_cin;

  // Divider
  logic          div_start, div_done;
  logic [RW-1:0] div_dividend, div_quo, div_rem;

  // Decisions
  logic          idx_bad, q_bad, q_empty, head_go, blocks_go, tail_go;
  logic [RW:0]   blk_end;
  logic [RW-1:0] off_inc;
  logic [TW-1:0] elem_sx, val_sx;

  assign elem_sx = {{(TW-EW){elem_q[EW-1]}}, elem_q};
  assign val_sx  = {{(TW-EW){val[EW-1]}}, val};

  assign idx_bad = {1'b0, item.element_index} >= cfg.len;
  assign q_bad   = ({1'b0, item.range_start} >= cfg.len) ||
                   ({1'b0, item.range_end} >= cfg.len);
  assign q_empty = item.range_start > item.range_end;

  assign off_inc   = off + RW'(1);
  assign blk_end   = {1'b0, pos} + {1'b0, cfg.blk};
  assign head_go   = (off != '0) && (pos <= last);
  assign blocks_go = blk_end <= ({1'b0, last} + (RW+1)'(1));
  assign tail_go   = pos <= last;

  assign alu_y = alu_a + alu_b + TW'(alu_cin);

  assign div_dividend = (item.opcode == brs_pkg::OP_WRITE) ?
                        {1'b0, item.element_index} : {1'b0, item.range_start};

  brs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.blk),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      brs_pkg::ST_CLEAR: begin
        if (clr_addr == ClrLast) state_next = brs_pkg::ST_IDLE;
      end
      brs_pkg::ST_IDLE: begin
        if (start) begin
          if (item.opcode == brs_pkg::OP_WRITE) begin
            state_next = idx_bad ? brs_pkg::ST_DONE : brs_pkg::ST_DIV;
          end else begin
            state_next = (q_bad || q_empty) ? brs_pkg::ST_DONE : brs_pkg::ST_DIV;
          end
        end
      end
      brs_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (op == brs_pkg::OP_WRITE) ? brs_pkg::ST_WR_READ : brs_pkg::ST_HEAD;
        end
      end
      brs_pkg::ST_WR_READ:  state_next = brs_pkg::ST_WR_DIFF;
      brs_pkg::ST_WR_DIFF:  state_next = brs_pkg::ST_WR_STORE;
      brs_pkg::ST_WR_STORE: state_next = brs_pkg::ST_DONE;
      brs_pkg::ST_HEAD: begin
        if (!head_go) state_next = brs_pkg::ST_BLOCKS;
      end
      brs_pkg::ST_BLOCKS: begin
        if (!blocks_go) state_next = brs_pkg::ST_TAIL;
      end
      brs_pkg::ST_TAIL: begin
        if (!tail_go) state_next = brs_pkg::ST_DONE;
      end
      brs_pkg::ST_DONE: begin
        if (res_ready) state_next = brs_pkg::ST_IDLE;
      end
      default: state_next = brs_pkg::ST_CLEAR;
    endcase
    if (clear_req) state_next = brs_pkg::ST_CLEAR;
  end

  // Outputs: memory ports, adder operands, divider start
  always_comb begin
    elem_re    = 1'b0;
    bsum_re    = 1'b0;
    elem_we    = 1'b0;
    bsum_we    = 1'b0;
    elem_raddr = AW'(idx);
    bsum_raddr = AW'(blk);
    elem_waddr = AW'(idx);
    bsum_waddr = AW'(blk);
    elem_wdata = val;
    bsum_wdata = alu_y;
    div_start  = 1'b0;
    alu_a      = sum;
    alu_b      = pend_bsum ? bsum_q : elem_sx;
    alu_cin    = 1'b0;
    idle       = 1'b0;
    res_valid  = 1'b0;
    case (state)
      brs_pkg::ST_CLEAR: begin
        elem_we    = 1'b1;
        bsum_we    = 1'b1;
        elem_waddr = clr_addr;
        bsum_waddr = clr_addr;
        elem_wdata = '0;
        bsum_wdata = '0;
      end
      brs_pkg::ST_IDLE: begin
        idle      = 1'b1;
        div_start = start && ((item.opcode == brs_pkg::OP_WRITE) ? !idx_bad :
                              !(q_bad || q_empty));
      end
      brs_pkg::ST_WR_READ: begin
        elem_re = 1'b1;
        bsum_re = 1'b1;
      end
      brs_pkg::ST_WR_DIFF: begin
        // new value minus old value
        alu_a   = val_sx;
        alu_b   = ~elem_sx;
        alu_cin = 1'b1;
      end
      brs_pkg::ST_WR_STORE: begin
        alu_a   = bsum_q;
        alu_b   = sum;
        elem_we = 1'b1;
        bsum_we = 1'b1;
      end
      brs_pkg::ST_HEAD: begin
        elem_re    = head_go;
        elem_raddr = AW'(pos);
      end
      brs_pkg::ST_BLOCKS: begin
        bsum_re    = blocks_go;
        bsum_raddr = AW'(blk);
      end
      brs_pkg::ST_TAIL: begin
        elem_re    = tail_go;
        elem_raddr = AW'(pos);
      end
      brs_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res.range_total = sum;
  assign res.status      = status;

  // Memories with registered read data
  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    if (elem_re) elem_q <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (bsum_we) bsum_mem[bsum_waddr] <= bsum_wdata;
    if (bsum_re) bsum_q <= bsum_mem[bsum_raddr];
  end

  // Read-pending flags: data lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_elem <= 1'b0;
      pend_bsum <= 1'b0;
      clr_addr  <= '0;
    end else begin
      pend_elem <= ((state == brs_pkg::ST_HEAD) && head_go) ||
                   ((state == brs_pkg::ST_TAIL) && tail_go);
      pend_bsum <= (state == brs_pkg::ST_BLOCKS) && blocks_go;
      if (clear_req) begin
        clr_addr <= '0;
      end else if (state == brs_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Item, walk pointers and accumulator
  always_ff @(posedge clk) begin
    if ((state == brs_pkg::ST_IDLE) && start) begin
      op     <= item.opcode;
      idx    <= item.element_index;
      val    <= item.element_value[EW-1:0];
      pos    <= {1'b0, item.range_start};
      last   <= {1'b0, item.range_end};
      sum    <= '0;
      status <= ((item.opcode == brs_pkg::OP_WRITE) ? idx_bad : q_bad) ?
                brs_pkg::STATUS_RANGE : brs_pkg::STATUS_OK;
    end else begin
      if ((state == brs_pkg::ST_DIV) && div_done) begin
        blk <= div_quo;
        off <= div_rem;
      end
      // head: single elements up to a block boundary
      if ((state == brs_pkg::ST_HEAD) && head_go) begin
        pos <= pos + RW'(1);
        if (off_inc == cfg.blk) begin
          off <= '0;
          blk <= blk + RW'(1);
        end else begin
          off <= off_inc;
        end
      end
      // whole blocks
      if ((state == brs_pkg::ST_BLOCKS) && blocks_go) begin
        pos <= blk_end[RW-1:0];
        blk <= blk + RW'(1);
      end
      // tail elements
      if ((state == brs_pkg::ST_TAIL) && tail_go) begin
        pos <= pos + RW'(1);
      end
      if (state == brs_pkg::ST_WR_DIFF) begin
        sum <= alu_y;
      end else if (state == brs_pkg::ST_WR_STORE) begin
        sum <= '0;
      end else if (pend_elem || pend_bsum) begin
        sum <= alu_y;
      end
    end
  end

endmodule

FILE: src/block_decomposed_range_sum_core.sv
// ----------------------------------------------------------------------------
// block_decomposed_range_sum_core
// Range sum store split into blocks with one running sum per block.
// ----------------------------------------------------------------------------
// One item at a time. A write runs a block divide (11 quotient steps and a
// completion step), a read of the old element and block sum, a difference
// step, a store, the result hand-off and the idle state that takes the next
// item. A query runs the same divide and then walks the single elements
// before the first whole block, the whole blocks in the range and the single
// elements after the last whole block; the walk is paced by one read per
// cycle from the element or block-sum memory and one add per cycle in the
// shared 42-bit adder. An item with an index out of range, or a query with an
// empty range, skips the divide and goes straight to the result hand-off. A
// result may wait in the engine for the output register to free up.
// After reset, and after every write to block_length, a clearing pass zeros
// both memories, during which no item is taken; register writes are taken as
// ever. A finished result waits in an output register, so the next item may
// be taken before it is collected.
// ----------------------------------------------------------------------------
module block_decomposed_range_sum_core #(
  parameter int MAX_ELEMENTS  = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [brs_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [brs_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [brs_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [brs_pkg::INDEX_W-1:0]          element_index,
  input  logic signed [brs_pkg::VALUE_W-1:0]   element_value,
  input  logic [brs_pkg::INDEX_W-1:0]          range_start,
  input  logic [brs_pkg::INDEX_W-1:0]          range_end,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [brs_pkg::TOTAL_W-1:0]   range_total,
  output logic                                 status
);

  localparam int RW        = brs_pkg::REG_W;
  localparam int RegMax    = (1 << RW) - 1;
  localparam int LenCapInt = (MAX_ELEMENTS < RegMax) ? MAX_ELEMENTS : RegMax;
  localparam logic [RW-1:0] LenCap = LenCapInt[RW-1:0];

  logic [RW-1:0]    array_length;
  logic [RW-1:0]    block_length;
  logic             cfg_wr;
  logic             clear_req;
  brs_pkg::cfg_t    cfg;
  brs_pkg::item_t   item;
  brs_pkg::result_t res;
  logic             eng_idle;
  logic             res_valid;
  logic             res_ready;

  // Register file
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign clear_req = cfg_wr && (paddr[2] == brs_pkg::REG_SEL_BLOCK_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= brs_pkg::ARRAY_LENGTH_RST;
      block_length <= brs_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == brs_pkg::REG_SEL_BLOCK_LENGTH) begin
        block_length <= pwdata[RW-1:0];
      end else begin
        array_length <= pwdata[RW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == brs_pkg::REG_SEL_BLOCK_LENGTH) ?
                  {{(brs_pkg::APB_DATA_W - RW){1'b0}}, block_length} :
                  {{(brs_pkg::APB_DATA_W - RW){1'b0}}, array_length};

  // Effective length and block length
  assign cfg.len = (array_length < LenCap) ? array_length : LenCap;
  assign cfg.blk = (block_length == '0) ? RW'(1) : block_length;

  assign item.opcode        = opcode;
  assign item.element_index = element_index;
  assign item.element_value = element_value;
  assign item.range_start   = range_start;
  assign item.range_end     = range_end;

  assign in_ready = eng_idle;

  brs_engine #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .item      (item),
    .cfg       (cfg),
    .clear_req (clear_req),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      range_total <= res.range_total;
      status      <= res.status;
    end
  end

endmodule

FILE: src/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks for the range sum core, bound to the top level.
// ----------------------------------------------------------------------------
module brs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [brs_pkg::TOTAL_W-1:0] range_total,
  input logic                               status
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_total) && $stable(status))
    else $error("result changed while stalled");

  // Range errors carry a zero total
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == brs_pkg::STATUS_RANGE) |-> range_total == '0)
    else $error("range error with nonzero total");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // Clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready during clearing pass");

endmodule

bind block_decomposed_range_sum_core brs_checker u_brs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .range_total (range_total),
  .status      (status)
);
